>>> hw/rtl/lfmp_pkg.sv
// Shared types and constants for the latest-frame mailbox with frame pacing.
// Used by every module of the block; depends on nothing else.
package lfmp_pkg;

	// Field widths of the stream words.
	localparam int CMD_W    = 3;
	localparam int SLOT_W   = 8;
	localparam int TIME_W   = 64;
	localparam int STATUS_W = 2;
	localparam int DROP_W   = 32;
	localparam int RATE_W   = 10;

	// Packed word widths; the stream word widths are rounded up to whole bytes.
	localparam int IN_W       = CMD_W + SLOT_W + TIME_W;
	localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
	localparam int RES_W      = STATUS_W + 1 + SLOT_W + SLOT_W + 1 + DROP_W;
	localparam int OUT_W      = ((RES_W + 7) / 8) * 8;

	// Bit offsets inside the input word.
	localparam int SLOT_LSB = CMD_W;
	localparam int TIME_LSB = CMD_W + SLOT_W;

	// Frame pacing: the interval is ceil(FRAME_MS / rate).
	localparam int FRAME_MS = 1000;
	localparam int RATE_MAX = 1000;
	localparam int DVD_W    = 11;
	localparam int CNT_W    = 4;

	// Configuration port.
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_OFFER    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TAKE     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUE      = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STS_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] STS_STOPPED = 2'd2;
	localparam logic [STATUS_W-1:0] STS_NONE    = 2'd3;

	// Register word index of frame_rate.
	localparam logic REG_FRAME_RATE = 1'b0;

	// Result word, laid out so that status sits in the lowest bits.
	typedef struct packed {
		logic [DROP_W-1:0]   drop_total;
		logic                frame_due;
		logic [SLOT_W-1:0]   granted_slot;
		logic [SLOT_W-1:0]   displaced_slot;
		logic                replaced;
		logic [STATUS_W-1:0] status;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start_div;
		logic add;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic due_go;
		logic div_done;
		logic halted;
	} dp_stat_t;

endpackage

>>> hw/rtl/lfmp_div.sv
// Serial restoring divider that produces the frame interval ceil(1000 / rate).
// One quotient bit per cycle; uses lfmp_pkg for widths and constants.
module lfmp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lfmp_pkg::RATE_W-1:0]  rate,
	output logic                         done,
	output logic [lfmp_pkg::RATE_W-1:0]  interval
);

	logic [lfmp_pkg::DVD_W-1:0]  dvd_q;
	logic [lfmp_pkg::DVD_W-1:0]  quo_q;
	logic [lfmp_pkg::RATE_W-1:0] rem_q;
	logic [lfmp_pkg::RATE_W-1:0] div_q;
	logic [lfmp_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [lfmp_pkg::DVD_W-1:0]  rem_shift;
	logic [lfmp_pkg::DVD_W:0]    diff;
	logic                        fits;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		rem_shift = {rem_q, dvd_q[lfmp_pkg::DVD_W-1]};
		diff      = {1'b0, rem_shift} - {2'b00, div_q};
		fits      = !diff[lfmp_pkg::DVD_W];
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lfmp_pkg::CNT_W'(lfmp_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lfmp_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend, remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= lfmp_pkg::DVD_W'(lfmp_pkg::FRAME_MS - 1) + lfmp_pkg::DVD_W'(rate);
			div_q <= rate;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[lfmp_pkg::DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[lfmp_pkg::RATE_W-1:0] : rem_shift[lfmp_pkg::RATE_W-1:0];
			quo_q <= {quo_q[lfmp_pkg::DVD_W-2:0], fits};
		end
	end

	// The quotient never exceeds 1000, so ten bits hold it.
	assign done     = done_q;
	assign interval = quo_q[lfmp_pkg::RATE_W-1:0];

endmodule

>>> hw/rtl/lfmp_dp.sv
// Datapath of the mailbox: slot state, drop counter, frame timer and result word.
// Depends on lfmp_pkg and instantiates lfmp_div.
module lfmp_dp #(
	parameter int SLOT_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lfmp_pkg::ctrl_cmd_t            cmd,
	output lfmp_pkg::dp_stat_t             stat,
	input  logic [lfmp_pkg::CMD_W-1:0]     in_command,
	input  logic [lfmp_pkg::SLOT_W-1:0]    in_slot,
	input  logic [lfmp_pkg::TIME_W-1:0]    in_now,
	input  logic [lfmp_pkg::RATE_W-1:0]    frame_rate,
	output lfmp_pkg::res_t                 result
);

	// Stored slot ids are no wider than the slot field.
	localparam int ID_W = (SLOT_BITS < lfmp_pkg::SLOT_W) ? SLOT_BITS : lfmp_pkg::SLOT_W;

	// Latched item.
	logic [lfmp_pkg::CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]             slot_q;
	logic [lfmp_pkg::TIME_W-1:0] now_q;

	// Mailbox and pacer state.
	logic                        pend_valid_q;
	logic [ID_W-1:0]             pend_id_q;
	logic                        busy_valid_q;
	logic [ID_W-1:0]             busy_id_q;
	logic                        halted_q;
	logic [lfmp_pkg::DROP_W-1:0] drop_q;
	logic [lfmp_pkg::TIME_W-1:0] next_time_q;
	logic [lfmp_pkg::TIME_W:0]   sum_q;
	lfmp_pkg::res_t              res_q;

	// Next-state values for a commit.
	logic                        pend_valid_d;
	logic [ID_W-1:0]             pend_id_d;
	logic                        busy_valid_d;
	logic [ID_W-1:0]             busy_id_d;
	logic                        halted_d;
	logic [lfmp_pkg::DROP_W-1:0] drop_d;
	logic [lfmp_pkg::TIME_W-1:0] next_time_d;
	lfmp_pkg::res_t              res_d;

	logic                        rate_ok;
	logic                        due_go;
	logic                        div_done;
	logic [lfmp_pkg::RATE_W-1:0] interval;

	lfmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.rate     (frame_rate),
		.done     (div_done),
		.interval (interval)
	);

	// A due check does real work only when running, paced and on time.
	always_comb begin
		rate_ok = (frame_rate != '0) &&
			(frame_rate <= lfmp_pkg::RATE_W'(lfmp_pkg::RATE_MAX));
		due_go  = (cmd_q == lfmp_pkg::CMD_DUE) && !halted_q && rate_ok &&
			(now_q >= next_time_q);
	end

	assign stat.due_go   = due_go;
	assign stat.div_done = div_done;
	assign stat.halted   = halted_q;

	// Effect of the latched command on the state and the result word.
	always_comb begin
		pend_valid_d = pend_valid_q;
		pend_id_d    = pend_id_q;
		busy_valid_d = busy_valid_q;
		busy_id_d    = busy_id_q;
		halted_d     = halted_q;
		drop_d       = drop_q;
		next_time_d  = next_time_q;
		res_d        = '0;
		res_d.status = lfmp_pkg::STS_OK;
		unique case (cmd_q)
			lfmp_pkg::CMD_OFFER: begin
				if (halted_q) begin
					res_d.status = lfmp_pkg::STS_STOPPED;
				end else if ((busy_valid_q && busy_id_q == slot_q) ||
					(pend_valid_q && pend_id_q == slot_q)) begin
					res_d.status = lfmp_pkg::STS_INVALID;
				end else begin
					res_d.replaced       = pend_valid_q;
					res_d.displaced_slot = lfmp_pkg::SLOT_W'(pend_id_q);
					if (pend_valid_q && drop_q != '1) begin
						drop_d = drop_q + 1'b1;
					end
					pend_id_d    = slot_q;
					pend_valid_d = 1'b1;
				end
			end
			lfmp_pkg::CMD_TAKE: begin
				if (halted_q) begin
					res_d.status = lfmp_pkg::STS_STOPPED;
				end else if (busy_valid_q || !pend_valid_q) begin
					res_d.status = lfmp_pkg::STS_NONE;
				end else begin
					res_d.granted_slot = lfmp_pkg::SLOT_W'(pend_id_q);
					busy_id_d          = pend_id_q;
					pend_valid_d       = 1'b0;
					busy_valid_d       = 1'b1;
				end
			end
			lfmp_pkg::CMD_COMPLETE: begin
				busy_valid_d = 1'b0;
			end
			lfmp_pkg::CMD_STOP: begin
				halted_d     = 1'b1;
				pend_valid_d = 1'b0;
				busy_valid_d = 1'b0;
			end
			lfmp_pkg::CMD_DUE: begin
				if (halted_q) begin
					res_d.status = lfmp_pkg::STS_STOPPED;
				end else if (!due_go || sum_q[lfmp_pkg::TIME_W]) begin
					// Off pace, early, or the next time would wrap past the top.
					res_d.status = lfmp_pkg::STS_NONE;
				end else begin
					next_time_d     = sum_q[lfmp_pkg::TIME_W-1:0];
					res_d.frame_due = 1'b1;
				end
			end
			default: begin
				res_d.status = lfmp_pkg::STS_INVALID;
			end
		endcase
		res_d.drop_total = drop_d;
	end

	// Item latch, interval sum and result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_command;
			slot_q <= in_slot[ID_W-1:0];
			now_q  <= in_now;
		end
		if (cmd.add) begin
			sum_q <= {1'b0, now_q} + (lfmp_pkg::TIME_W + 1)'(interval);
		end
		if (cmd.commit) begin
			res_q <= res_d;
		end
	end

	// Architectural state, updated once per item at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			busy_valid_q <= 1'b0;
			busy_id_q    <= '0;
			halted_q     <= 1'b0;
			drop_q       <= '0;
			next_time_q  <= '0;
		end else if (cmd.commit) begin
			pend_valid_q <= pend_valid_d;
			pend_id_q    <= pend_id_d;
			busy_valid_q <= busy_valid_d;
			busy_id_q    <= busy_id_d;
			halted_q     <= halted_d;
			drop_q       <= drop_d;
			next_time_q  <= next_time_d;
		end
	end

	assign result = res_q;

endmodule

>>> hw/rtl/lfmp_ctrl.sv
// Controller state machine of the mailbox: sequences accept, divide, add and commit.
// Depends on lfmp_pkg; drives the datapath only through command signals.
module lfmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lfmp_pkg::dp_stat_t  stat,
	output lfmp_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_ADD    = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a word when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.start_div = 1'b0;
		cmd.add       = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.start_div = stat.due_go;
				state_d       = stat.due_go ? S_DIV : S_EMIT;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.commit = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/latest_frame_mailbox_pacer_top.sv
// Top level of the latest-wins frame mailbox with frame pacer.
// Depends on lfmp_pkg, lfmp_ctrl, lfmp_dp and lfmp_div.
//
// Usage:
//   Commands arrive as words on the s_ stream (offer, take, complete, stop,
//   due check); each command yields exactly one result word on the m_ stream.
//   frame_rate is written over the APB port at byte address 0 while the block
//   is idle; pready is always high and reads return the register.
// Sequencing:
//   Offer, take, complete, stop, unused codes and a due check that fails the
//   early checks go from decode straight to emit, where the result word is
//   registered at commit. A due check that passes the early checks runs the
//   serial divider for eleven quotient bits, then a 64-bit add, before emit.
//   s_tready is high only between commands.
// Reset:
//   arst_n clears both flags, the ids, the stop latch, the drop counter, the
//   next frame time and frame_rate; no result word is pending after reset.
// Stall:
//   A finished result waits in the output register while the next command is
//   accepted; a second result waits until m_tready takes the first.
module latest_frame_mailbox_pacer_top #(
	parameter int SLOT_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Fields from bit 0: command[2:0], slot_id[10:3], now_ms[74:11], zero pad.
	input  logic [lfmp_pkg::IN_BYTES_W-1:0]   s_tdata,
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Fields from bit 0: status[1:0], replaced[2], displaced_slot[10:3],
	// granted_slot[18:11], frame_due[19], drop_total[51:20], zero pad.
	output logic [lfmp_pkg::OUT_W-1:0]        m_tdata,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lfmp_pkg::ADDR_W-1:0]       paddr,
	input  logic [lfmp_pkg::DATA_W-1:0]       pwdata,
	output logic [lfmp_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	logic [lfmp_pkg::RATE_W-1:0] frame_rate_q;
	logic                        reg_sel;
	lfmp_pkg::ctrl_cmd_t         cmd;
	lfmp_pkg::dp_stat_t          stat;
	lfmp_pkg::res_t              result;

	// Register decode uses the word index above the byte offset.
	assign reg_sel = (paddr[lfmp_pkg::ADDR_W-1] == lfmp_pkg::REG_FRAME_RATE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? lfmp_pkg::DATA_W'(frame_rate_q) : '0;

	// frame_rate register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rate_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			frame_rate_q <= pwdata[lfmp_pkg::RATE_W-1:0];
		end
	end

	lfmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lfmp_dp #(
		.SLOT_BITS (SLOT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (s_tdata[lfmp_pkg::CMD_W-1:0]),
		.in_slot    (s_tdata[lfmp_pkg::SLOT_LSB +: lfmp_pkg::SLOT_W]),
		.in_now     (s_tdata[lfmp_pkg::TIME_LSB +: lfmp_pkg::TIME_W]),
		.frame_rate (frame_rate_q),
		.result     (result)
	);

	assign m_tdata = lfmp_pkg::OUT_W'(result);

	// Only one command is in flight: acceptance closes the input until commit.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a command is still in work");

	// Stop latches until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.halted |=> stat.halted)
		else $error("stop latch was released");

	// A frame only fires with an ok status.
	a_due_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result.frame_due |-> result.status == lfmp_pkg::STS_OK)
		else $error("frame_due set with a failing status");

	// A replacement always leaves a nonzero drop count.
	a_drop_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result.replaced |-> result.drop_total != '0)
		else $error("replaced slot without a counted drop");

endmodule

>>> test/latest_frame_mailbox_pacer_top_test.sv
// Self-checking testbench for the latest-wins frame mailbox with frame pacer.
// Drives commands on the input stream and frame_rate over APB, and checks every result word.
// Depends on lfmp_pkg and latest_frame_mailbox_pacer_top.
`timescale 1ns / 1ps

module latest_frame_mailbox_pacer_top_test;
	import lfmp_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_WORDS = 180;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [ADDR_W-1:0] RATE_ADDR = ADDR_W'(4 * int'(REG_FRAME_RATE));

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_BYTES_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Mirror of the block's state, advanced once per accepted command word.
	logic pend_valid = 1'b0;
	logic [SLOT_W-1:0] pend_slot = '0;
	logic busy_valid = 1'b0;
	logic [SLOT_W-1:0] busy_slot = '0;
	logic stop_latched = 1'b0;
	logic [DROP_W-1:0] drop_tally = '0;
	logic [TIME_W-1:0] next_frame_at = '0;
	logic [RATE_W-1:0] rate_setting = '0;

	res_t awaited_replies[$];
	int failures = 0;
	int cycle_count = 0;
	logic tx_gaps_on = 1'b1;
	logic rx_stalls_on = 1'b1;
	int rx_mode_left = 0;
	int rx_stall_left = 0;
	logic [TIME_W-1:0] stim_clock = '0;

	latest_frame_mailbox_pacer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Applies one command to the mirrored state and returns the result it should give.
	function automatic res_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] now);
		res_t r;
		logic [TIME_W-1:0] interval;
		r = '0;
		case (cmd)
			CMD_OFFER: begin
				if (stop_latched) begin
					r.status = STS_STOPPED;
				end else if ((busy_valid && busy_slot == slot) ||
						(pend_valid && pend_slot == slot)) begin
					r.status = STS_INVALID;
				end else begin
					// The old pending id is reported even when nothing was pending.
					r.replaced = pend_valid;
					r.displaced_slot = pend_slot;
					if (pend_valid && drop_tally != '1)
						drop_tally = drop_tally + 1'b1;
					pend_slot = slot;
					pend_valid = 1'b1;
				end
			end
			CMD_TAKE: begin
				if (stop_latched) begin
					r.status = STS_STOPPED;
				end else if (busy_valid || !pend_valid) begin
					r.status = STS_NONE;
				end else begin
					r.granted_slot = pend_slot;
					busy_slot = pend_slot;
					pend_valid = 1'b0;
					busy_valid = 1'b1;
				end
			end
			CMD_COMPLETE: begin
				busy_valid = 1'b0;
			end
			CMD_STOP: begin
				stop_latched = 1'b1;
				pend_valid = 1'b0;
				busy_valid = 1'b0;
			end
			CMD_DUE: begin
				if (stop_latched) begin
					r.status = STS_STOPPED;
				end else if (rate_setting == 0 || rate_setting > RATE_MAX ||
						now < next_frame_at) begin
					r.status = STS_NONE;
				end else begin
					// Interval is the frame time rounded up; no catch-up on late checks.
					interval = TIME_W'((FRAME_MS + int'(rate_setting) - 1) / int'(rate_setting));
					if (now > TIME_MAX - interval) begin
						r.status = STS_NONE;
					end else begin
						next_frame_at = now + interval;
						r.frame_due = 1'b1;
					end
				end
			end
			default: begin
				r.status = STS_INVALID;
			end
		endcase
		r.drop_total = drop_tally;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
			failures++;
		end
	endtask

	// Result side: checks each accepted word and paces m_tready.
	always @(posedge clk) begin : reply_check
		res_t want;
		res_t got;
		int roll;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_W-1:0]);
			if (awaited_replies.size() == 0) begin
				$display("%0t: result word with no command waiting, got 0x%0h", $time, m_tdata);
				failures++;
			end else begin
				want = awaited_replies.pop_front();
				check_field("status", 64'(want.status), 64'(got.status));
				check_field("replaced", 64'(want.replaced), 64'(got.replaced));
				check_field("displaced_slot", 64'(want.displaced_slot),
					64'(got.displaced_slot));
				check_field("granted_slot", 64'(want.granted_slot), 64'(got.granted_slot));
				check_field("frame_due", 64'(want.frame_due), 64'(got.frame_due));
				check_field("drop_total", 64'(want.drop_total), 64'(got.drop_total));
				check_field("tdata padding", '0, 64'(m_tdata[OUT_W-1:RES_W]));
			end
		end
		// Stretches with random stalls mix with stretches where the sink always accepts.
		if (rx_mode_left == 0) begin
			rx_stalls_on = ($urandom_range(0, 2) != 0);
			rx_mode_left = $urandom_range(50, 300);
		end else begin
			rx_mode_left--;
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if (!rx_stalls_on) begin
			m_tready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				m_tready <= 1'b1;
			end else if (roll < 95) begin
				m_tready <= 1'b0;
				rx_stall_left = $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b0;
				rx_stall_left = $urandom_range(10, 40);
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!tx_gaps_on || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// Sends one command word and records the result it should give.
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
			input logic [TIME_W-1:0] now);
		logic [IN_BYTES_W-1:0] word;
		int gap;
		word = '0;
		word[CMD_W-1:0] = cmd;
		word[SLOT_LSB +: SLOT_W] = slot;
		word[TIME_LSB +: TIME_W] = now;
		s_tdata <= word;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		awaited_replies.push_back(apply_command(cmd, slot, now));
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every result word has come back.
	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
	endtask

	// Writes frame_rate while the block is idle, then reads it back.
	task automatic write_frame_rate(input logic [DATA_W-1:0] value);
		wait_for_replies();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RATE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rate_setting = value[RATE_W-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("frame_rate readback", 64'(rate_setting), 64'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer, take and complete, with both kinds of refused offer and take, and the unused codes.
	task automatic test_mailbox_handoff();
		send_command(CMD_OFFER, 8'h00, '0);
		send_command(CMD_OFFER, 8'h00, '0);
		send_command(CMD_OFFER, 8'hFF, TIME_MAX);
		send_command(CMD_TAKE, 8'h00, '0);
		send_command(CMD_TAKE, 8'h00, '0);
		send_command(CMD_OFFER, 8'hFF, '0);
		send_command(CMD_OFFER, 8'hAA, 64'h5555_5555_5555_5555);
		send_command(CMD_COMPLETE, 8'h00, '0);
		send_command(CMD_TAKE, 8'h55, 64'hAAAA_AAAA_AAAA_AAAA);
		send_command(CMD_TAKE, 8'h00, '0);
		send_command(CMD_COMPLETE, 8'h00, '0);
		send_command(CMD_COMPLETE, 8'h00, '0);
		for (int code = int'(CMD_DUE) + 1; code <= int'(CMD_SPARE_LAST); code++)
			send_command(CMD_W'(code), 8'h00, '0);
	endtask

	// Due check refused for a zero or out-of-range rate, and paced at the extremes.
	task automatic test_due_gating();
		write_frame_rate(0);
		send_command(CMD_DUE, 8'h00, '0);
		write_frame_rate(1023);
		send_command(CMD_DUE, 8'h00, 64'd10);
		write_frame_rate(RATE_MAX + 1);
		send_command(CMD_DUE, 8'h00, 64'd10);
		write_frame_rate(RATE_MAX);
		send_command(CMD_DUE, 8'h00, '0);
		send_command(CMD_DUE, 8'h00, '0);
		write_frame_rate(1);
		send_command(CMD_DUE, 8'h00, 64'd1);
		send_command(CMD_DUE, 8'h00, 64'd1000);
		send_command(CMD_DUE, 8'h00, 64'd1001);
	endtask

	// Draws one command from the traffic mix of a running or a stopped block.
	task automatic send_random_command(input logic allow_stop);
		logic [CMD_W-1:0] cmd;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			cmd = CMD_OFFER;
		else if (roll < 60)
			cmd = CMD_TAKE;
		else if (roll < 74)
			cmd = CMD_COMPLETE;
		else if (roll < 94)
			cmd = CMD_DUE;
		else if (roll < 97 && allow_stop)
			cmd = CMD_STOP;
		else
			cmd = CMD_W'($urandom_range(int'(CMD_DUE) + 1, int'(CMD_SPARE_LAST)));
		// Reuse held ids often so that refused offers come up regularly.
		roll = $urandom_range(0, 99);
		if (roll < 10)
			slot = pend_slot;
		else if (roll < 20)
			slot = busy_slot;
		else if (roll < 55)
			slot = SLOT_W'($urandom_range(0, 3));
		else
			slot = SLOT_W'($urandom_range(0, 255));
		if (cmd == CMD_DUE) begin
			stim_clock = stim_clock + TIME_W'($urandom_range(0, 300));
			now = stim_clock;
		end else begin
			now = {$urandom(), $urandom()};
		end
		send_command(cmd, slot, now);
	endtask

	// Random traffic over a series of frame rates, the extremes among them.
	task automatic test_random_traffic();
		int rates[8];
		logic [DATA_W-1:0] value;
		rates = '{7, RATE_MAX, 1, 333, 0, RATE_MAX + 1, 999, -1};
		foreach (rates[p]) begin
			if (rates[p] < 0)
				value = DATA_W'($urandom_range(1, RATE_MAX));
			else
				value = DATA_W'(rates[p]);
			// Upper write bits are outside the register and must be dropped.
			if (p % 2 == 1)
				value = value | ($urandom() & ~DATA_W'({RATE_W{1'b1}}));
			write_frame_rate(value);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 60 == 0)
					tx_gaps_on = ($urandom_range(0, 3) != 0);
				// Now and then the sender holds off until the block has drained.
				if ($urandom_range(0, 99) == 0)
					wait_for_replies();
				send_random_command(1'b0);
			end
		end
	endtask

	// A due check whose next frame time would pass the top of the time range is refused.
	task automatic test_time_overflow();
		write_frame_rate(3);
		send_command(CMD_DUE, 8'h00, TIME_MAX - 333);
		send_command(CMD_DUE, 8'h00, TIME_MAX - 334);
		send_command(CMD_DUE, 8'h00, TIME_MAX - 1);
		send_command(CMD_DUE, 8'h00, TIME_MAX);
	endtask

	// Stop latches until reset; only complete, stop and unused codes still answer normally.
	task automatic test_stopped_block();
		write_frame_rate(RATE_MAX);
		send_command(CMD_OFFER, 8'h21, '0);
		send_command(CMD_TAKE, 8'h00, '0);
		send_command(CMD_STOP, 8'h00, '0);
		send_command(CMD_OFFER, 8'h09, '0);
		send_command(CMD_TAKE, 8'h00, '0);
		send_command(CMD_DUE, 8'h00, TIME_MAX - 5);
		send_command(CMD_COMPLETE, 8'h00, '0);
		send_command(CMD_STOP, 8'h00, '0);
		send_command(CMD_SPARE_LAST, 8'h00, '0);
		for (int n = 0; n < 60; n++)
			send_random_command(1'b1);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mailbox_handoff();
		test_due_gating();
		test_random_traffic();
		test_time_overflow();
		test_stopped_block();
		wait_for_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
